[hw/rtl/esd_pkg.sv]
// Shared types, character codes and helpers for the escape sequence decoder.
package esd_pkg;

  // Decoder phase between input requests
  typedef enum logic [2:0] {
    PH_PLAIN = 3'd0,
    PH_ESC   = 3'd1,
    PH_CARET = 3'd2,
    PH_OCT1  = 3'd3,
    PH_OCT2  = 3'd4,
    PH_HEX0  = 3'd5,
    PH_HEX1  = 3'd6
  } esd_phase_t;

  // Maximum number of decoded bytes one input byte can produce
  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  // Character codes
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_TAB   = 8'h09;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CARET_OFS = 8'd64;

  // Decoded bytes produced by one input request
  typedef struct packed {
    logic [CntW-1:0]             count;
    logic [MaxResults-1:0]       last;
    logic [MaxResults-1:0][7:0]  data;
  } esd_result_t;

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_7);
  endfunction

  function automatic logic is_letter_hex(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_F)) || ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || is_letter_hex(c);
  endfunction

  // Letters a-f and A-F both carry 1..6 in the low nibble
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return is_letter_hex(c) ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

endpackage

[hw/rtl/esd_core.sv]
// Escape decoding state and the per-byte decode logic.
module esd_core
  import esd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [7:0]  byte_in,
  input  logic        last_in,
  output esd_result_t result
);

  esd_phase_t phase_r, phase_nxt;
  logic [7:0] partial_r, partial_nxt;
  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;

  logic [CntW-1:0]            n;
  logic [MaxResults-1:0][7:0] data;
  logic [MaxResults-1:0]      lastm;
  logic                       feed_plain;

  // Decode one byte: next phase, held digits and the bytes it yields
  always_comb begin
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    held0_nxt   = held0_r;
    held1_nxt   = held1_r;
    n           = '0;
    data        = '0;
    lastm       = '0;
    feed_plain  = 1'b0;

    case (phase_r)
      PH_ESC: begin
        phase_nxt = PH_PLAIN;
        if (byte_in == CH_N) begin
          data[n] = CTL_LF; n = n + 1'b1;
        end else if (byte_in == CH_R) begin
          data[n] = CTL_CR; n = n + 1'b1;
        end else if (byte_in == CH_T) begin
          data[n] = CTL_TAB; n = n + 1'b1;
        end else if (byte_in == CH_B) begin
          data[n] = CTL_BS; n = n + 1'b1;
        end else if ((byte_in >= CH_0) && (byte_in <= CH_3)) begin
          held0_nxt   = byte_in;
          partial_nxt = {byte_in[1:0], 6'd0};
          phase_nxt   = PH_OCT1;
        end else if (byte_in == CH_X) begin
          phase_nxt = PH_HEX0;
        end else begin
          data[n] = byte_in; n = n + 1'b1;
        end
      end
      PH_CARET: begin
        phase_nxt = PH_PLAIN;
        data[n] = byte_in - CARET_OFS; n = n + 1'b1;
      end
      PH_OCT1: begin
        if (is_oct(byte_in)) begin
          held1_nxt   = byte_in;
          partial_nxt = partial_r + {2'd0, byte_in[2:0], 3'd0};
          phase_nxt   = PH_OCT2;
        end else begin
          data[n] = held0_r; n = n + 1'b1;
          feed_plain = 1'b1;
        end
      end
      PH_OCT2: begin
        if (is_oct(byte_in)) begin
          phase_nxt = PH_PLAIN;
          data[n] = partial_r + {5'd0, byte_in[2:0]}; n = n + 1'b1;
        end else begin
          data[n] = held0_r; n = n + 1'b1;
          data[n] = held1_r; n = n + 1'b1;
          feed_plain = 1'b1;
        end
      end
      PH_HEX0: begin
        if (is_hex(byte_in)) begin
          held0_nxt   = byte_in;
          partial_nxt = {hex_val(byte_in), 4'd0};
          phase_nxt   = PH_HEX1;
        end else begin
          data[n] = CH_X; n = n + 1'b1;
          feed_plain = 1'b1;
        end
      end
      PH_HEX1: begin
        if (is_hex(byte_in)) begin
          phase_nxt = PH_PLAIN;
          data[n] = partial_r | {4'd0, hex_val(byte_in)}; n = n + 1'b1;
        end else begin
          data[n] = CH_X; n = n + 1'b1;
          data[n] = held0_r; n = n + 1'b1;
          feed_plain = 1'b1;
        end
      end
      default: begin
        feed_plain = 1'b1;
      end
    endcase

    // Ordinary text handling, also used to replay a byte after a failed escape
    if (feed_plain) begin
      if (byte_in == CH_BSL) begin
        phase_nxt = PH_ESC;
      end else if (byte_in == CH_CARET) begin
        phase_nxt = PH_CARET;
      end else begin
        phase_nxt = PH_PLAIN;
        data[n] = byte_in; n = n + 1'b1;
      end
    end

    // End of string: flush whatever an open escape still holds
    if (last_in) begin
      case (phase_nxt)
        PH_ESC: begin
          data[n] = CH_BSL; n = n + 1'b1;
        end
        PH_CARET: begin
          data[n] = CH_CARET; n = n + 1'b1;
        end
        PH_OCT1: begin
          data[n] = held0_nxt; n = n + 1'b1;
        end
        PH_OCT2: begin
          data[n] = held0_nxt; n = n + 1'b1;
          data[n] = held1_nxt; n = n + 1'b1;
        end
        PH_HEX0: begin
          data[n] = CH_X; n = n + 1'b1;
        end
        PH_HEX1: begin
          data[n] = CH_X; n = n + 1'b1;
          data[n] = held0_nxt; n = n + 1'b1;
        end
        default: begin
        end
      endcase
      phase_nxt = PH_PLAIN;
      if (n != '0) begin
        lastm[n - 1'b1] = 1'b1;
      end
    end

    result.count = n;
    result.last  = lastm;
    result.data  = data;
  end

  // Phase and held digits advance on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PLAIN;
      partial_r <= '0;
      held0_r   <= '0;
      held1_r   <= '0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
      held0_r   <= held0_nxt;
      held1_r   <= held1_nxt;
    end
  end

endmodule

[hw/rtl/escape_sequence_decoder_unit.sv]
// Escape sequence decoder: stream top level with a four-entry result queue.
// The decoded bytes of an accepted request are registered into the result queue.
// Throughput: one byte per cycle while out_tready stays high and each byte yields at most
// one result; a byte that yields more holds in_tready low until one result is left waiting.
// in_tready is high whenever at most one result is waiting in the queue.
// Reset (rst_n low, synchronous) returns to plain text and empties the queue.
module escape_sequence_decoder_unit
  import esd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  esd_result_t     result;
  logic            take;
  logic            pop;
  logic [8:0]      queue_r [QDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] count_r, count_nxt;

  assign take       = in_tvalid && in_tready;
  assign pop        = out_tvalid && out_tready;
  assign in_tready  = (count_r <= QCntW'(QDepth - MaxResults));
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = queue_r[rd_ptr_r][7:0];
  assign out_tlast  = queue_r[rd_ptr_r][8];

  esd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .byte_in (in_tdata),
    .last_in (in_tlast),
    .result  (result)
  );

  // Queue occupancy after this cycle's push and pop
  always_comb begin
    count_nxt = count_r;
    if (take) begin
      count_nxt = count_nxt + QCntW'(result.count);
    end
    if (pop) begin
      count_nxt = count_nxt - 1'b1;
    end
  end

  // Queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (take) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(result.count);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Queue storage: up to three decoded bytes written per request
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MaxResults; i++) begin
        if (CntW'(i) < result.count) begin
          queue_r[wr_ptr_r + PtrW'(i)] <= {result.last[i], result.data[i]};
        end
      end
    end
  end

endmodule

[hw/rtl/esd_checker.sv]
// Port-level checks for the escape sequence decoder, bound to the top level.
module esd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Reset leaves no decoded byte pending
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // An empty result queue always takes a new request
  assert property (@(posedge clk) disable iff (!rst_n) !out_tvalid |-> in_tready)
    else $error("input stalled with nothing to deliver");

  // The last byte of a string always yields at least one result
  assert property (@(posedge clk) disable iff (!rst_n)
      in_tvalid && in_tready && in_tlast && !out_tvalid |=> out_tvalid)
    else $error("end of string produced no result");

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind escape_sequence_decoder_unit esd_checker u_esd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[bench/tb.sv]
// Self-checking stream testbench for the escape sequence decoder unit.
`timescale 1ns / 1ps

module tb
  import esd_pkg::*;
();

  localparam int unsigned StallLimit = 2000;

  // One decoded byte as it should leave the block
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } decoded_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_byte
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;

  // Decoder state mirrored by the predictor
  esd_phase_t dec_phase   = PH_PLAIN;
  logic [7:0] dec_partial = 8'd0;
  logic [7:0] dec_held0   = 8'd0;
  logic [7:0] dec_held1   = 8'd0;

  decoded_byte_t decoded_q[$];
  logic [7:0]    step_bytes[$];
  logic [7:0]    text_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int bytes_checked  = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  escape_sequence_decoder_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Character classes used by the predictor.
  function automatic logic octal_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_7);
  endfunction

  function automatic logic hex_digit(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if ((c >= CH_LO_A) && (c <= CH_LO_F)) v = c - CH_LO_A + 8'd10;
    else if ((c >= CH_UP_A) && (c <= CH_UP_F)) v = c - CH_UP_A + 8'd10;
    else v = c - CH_0;
    return v[3:0];
  endfunction

  function automatic void emit(input logic [7:0] b);
    step_bytes.push_back(b);
  endfunction

  // A byte seen in plain text either opens an escape or passes through.
  function automatic void take_plain(input logic [7:0] c);
    if (c == CH_BSL) dec_phase = PH_ESC;
    else if (c == CH_CARET) dec_phase = PH_CARET;
    else begin
      dec_phase = PH_PLAIN;
      emit(c);
    end
  endfunction

  // Works out the decoded bytes caused by one accepted input byte.
  function automatic void decode_step(input logic [7:0] c, input logic lst);
    int n;
    step_bytes.delete();
    case (dec_phase)
      PH_ESC: begin
        dec_phase = PH_PLAIN;
        case (c)
          CH_N: emit(CTL_LF);
          CH_R: emit(CTL_CR);
          CH_T: emit(CTL_TAB);
          CH_B: emit(CTL_BS);
          CH_X: dec_phase = PH_HEX0;
          default: begin
            if ((c >= CH_0) && (c <= CH_3)) begin
              dec_held0   = c;
              dec_partial = {c[1:0], 6'd0};
              dec_phase   = PH_OCT1;
            end else begin
              emit(c);
            end
          end
        endcase
      end
      PH_CARET: begin
        dec_phase = PH_PLAIN;
        emit(c - CARET_OFS);
      end
      PH_OCT1: begin
        if (octal_digit(c)) begin
          dec_held1   = c;
          dec_partial = dec_partial + {2'd0, c[2:0], 3'd0};
          dec_phase   = PH_OCT2;
        end else begin
          emit(dec_held0);
          take_plain(c);
        end
      end
      PH_OCT2: begin
        if (octal_digit(c)) begin
          dec_phase = PH_PLAIN;
          emit(dec_partial + {5'd0, c[2:0]});
        end else begin
          emit(dec_held0);
          emit(dec_held1);
          take_plain(c);
        end
      end
      PH_HEX0: begin
        if (hex_digit(c)) begin
          dec_held0   = c;
          dec_partial = {hex_nibble(c), 4'd0};
          dec_phase   = PH_HEX1;
        end else begin
          emit(CH_X);
          take_plain(c);
        end
      end
      PH_HEX1: begin
        if (hex_digit(c)) begin
          dec_phase = PH_PLAIN;
          emit(dec_partial | {4'd0, hex_nibble(c)});
        end else begin
          emit(CH_X);
          emit(dec_held0);
          take_plain(c);
        end
      end
      default: take_plain(c);
    endcase

    // The final byte of a string flushes whatever escape is still open.
    if (lst) begin
      case (dec_phase)
        PH_ESC:   emit(CH_BSL);
        PH_CARET: emit(CH_CARET);
        PH_OCT1:  emit(dec_held0);
        PH_OCT2: begin
          emit(dec_held0);
          emit(dec_held1);
        end
        PH_HEX0:  emit(CH_X);
        PH_HEX1: begin
          emit(CH_X);
          emit(dec_held0);
        end
        default: ;
      endcase
      dec_phase = PH_PLAIN;
    end

    n = step_bytes.size();
    for (int i = 0; i < n; i++) begin
      decoded_q.push_back('{value: step_bytes[i], last: lst && (i == n - 1)});
    end
  endfunction

  // Sends one byte, idling first at the current rate, and predicts its results.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    decode_step(b, lst);
    items_sent++;
  endtask

  // Sends the bytes held in text_q as one string.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
  endtask

  // Holds the sender off until every predicted byte has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] random_hex_char();
    int r;
    r = $urandom_range(21);
    if (r < 10) return CH_0 + 8'(r);
    else if (r < 16) return CH_LO_A + 8'(r - 10);
    else return CH_UP_A + 8'(r - 16);
  endfunction

  // Builds a string out of mostly well-formed escapes with random content.
  task automatic build_random_string();
    int ntok;
    int kind;
    int base;
    int cut;
    text_q.delete();
    ntok = $urandom_range(1, 5);
    repeat (ntok) begin
      kind = $urandom_range(9);
      base = text_q.size();
      case (kind)
        0, 1: text_q.push_back(any_byte());
        2: begin
          text_q.push_back(CH_BSL);
          case ($urandom_range(4))
            0: text_q.push_back(CH_N);
            1: text_q.push_back(CH_R);
            2: text_q.push_back(CH_T);
            3: text_q.push_back(CH_B);
            default: text_q.push_back(any_byte());
          endcase
        end
        3, 4: begin
          text_q.push_back(CH_BSL);
          text_q.push_back(CH_0 + 8'($urandom_range(3)));
          text_q.push_back(CH_0 + 8'($urandom_range(7)));
          text_q.push_back(CH_0 + 8'($urandom_range(7)));
          if ($urandom_range(3) == 0) text_q[base + $urandom_range(2, 3)] = any_byte();
        end
        5, 6: begin
          text_q.push_back(CH_BSL);
          text_q.push_back(CH_X);
          // Zero digits now and then so that a zero byte comes out
          text_q.push_back(($urandom_range(5) == 0) ? CH_0 : random_hex_char());
          text_q.push_back(($urandom_range(5) == 0) ? CH_0 : random_hex_char());
          if ($urandom_range(3) == 0) text_q[base + $urandom_range(2, 3)] = any_byte();
        end
        7: begin
          text_q.push_back(CH_CARET);
          text_q.push_back(any_byte());
        end
        8: begin
          text_q.push_back(CH_BSL);
          text_q.push_back(CH_0 + 8'($urandom_range(4, 7)));
        end
        default: begin
          repeat ($urandom_range(1, 3)) text_q.push_back(CH_LO_A + 8'($urandom_range(25)));
        end
      endcase
    end

    // Sometimes end the string in the middle of an escape.
    if (($urandom_range(3) == 0) && (text_q.size() > 1)) begin
      cut = $urandom_range(1, (text_q.size() - 1 < 3) ? text_q.size() - 1 : 3);
      repeat (cut) void'(text_q.pop_back());
    end
  endtask

  task automatic test_control_escapes();
    text_q = '{CH_BSL, CH_N, CH_BSL, CH_T};
    send_text();
    text_q = '{CH_BSL, CH_R, CH_BSL, CH_B};
    send_text();
  endtask

  task automatic test_octal_escapes();
    // Largest octal value, then an escape that breaks after one digit
    text_q = '{CH_BSL, CH_3, CH_7, CH_7};
    send_text();
    text_q = '{CH_BSL, "1", "q"};
    send_text();
  endtask

  task automatic test_hex_escapes();
    text_q = '{CH_BSL, CH_X, CH_UP_A, CH_0};
    send_text();
    text_q = '{CH_BSL, CH_X, CH_LO_F, "Z"};
    send_text();
  endtask

  task automatic test_caret_wrap();
    // Byte 01h wraps below zero; the largest byte passes as plain text
    text_q = '{CH_CARET, 8'h01, 8'hFF};
    send_text();
  endtask

  task automatic test_trailing_escapes();
    text_q = '{CH_BSL};
    send_text();
    text_q = '{CH_CARET};
    send_text();
  endtask

  task automatic test_random_strings(input int count, input int idle_pct, input int stall_pct);
    int target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + count;
    while (items_sent < target) begin
      build_random_string();
      send_text();
    end
  endtask

  // Receiver: stalls at random at the current rate.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted decoded byte with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual byte %02h last %0b",
                 $time, out_tdata, out_tlast);
        mismatches++;
      end else begin
        if (out_tdata !== decoded_q[0].value) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, decoded_q[0].value, out_tdata);
          mismatches++;
        end
        if (out_tlast !== decoded_q[0].last) begin
          $display("%0t: out_last mismatch: expected %0b, actual %0b",
                   $time, decoded_q[0].last, out_tlast);
          mismatches++;
        end
        void'(decoded_q.pop_front());
        bytes_checked++;
      end
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    in_tlast  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_control_escapes();
    test_octal_escapes();
    test_hex_escapes();
    test_caret_wrap();
    test_trailing_escapes();

    test_random_strings(58, 0, 0);
    wait_drained();
    test_random_strings(58, 82, 0);
    test_random_strings(58, 0, 82);
    test_random_strings(58, 37, 37);

    // Let the result queue empty out, then a few more cycles for stray bytes.
    wait_drained();
    repeat (10) @(posedge clk);

    $display("tb: sent %0d bytes in short strings with open, broken and complete escapes,",
             items_sent);
    $display("tb: checked %0d decoded bytes under four idle and stall mixes",
             bytes_checked);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
